/* hdl/sse_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// sse_pkg: shared types and constants of the shell sort engine
// Element width, tally width and the sequencer state encoding.
// ---------------------------------------------------------------------------
package sse_pkg;

    localparam int SSE_MAX_ELEMS = 64;
    localparam int VALUE_W       = 32;
    localparam int TALLY_W       = 16;
    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

    typedef enum logic [3:0] {
        ST_LOAD,      // take elements
        ST_GAP,       // start a gap pass or finish sorting
        ST_ROW,       // fetch element i of the current pass
        ST_HELD,      // capture the held element
        ST_TEST,      // fetch the neighbor one gap below j
        ST_CMP,       // compare, shift up or stop
        ST_PLACE,     // write the held element at j
        ST_OUT_RD,    // fetch element k for output
        ST_OUT_LD,    // load the output register
        ST_OUT_HOLD   // offer the result until taken
    } sse_state_t;

endpackage
`default_nettype wire

/* hdl/sse_ram.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// sse_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ---------------------------------------------------------------------------
module sse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

/* hdl/shell_sort_engine_core.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// shell_sort_engine_core: Shell sort with halving gaps
// Collects a set of signed words, sorts it in place in one RAM with a
// gapped insertion sort per gap, and streams the set out in ascending order
// together with a saturating operation tally.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------
//   input   | in        | in_valid/in_ready  | elem_value, set_end
//   output  | out       | out_valid/out_ready| sorted_value, op_count, out_last
//
// Loading takes one transaction per cycle. After the set_end transaction the
// sort runs on the single RAM port pair: each gap pass walks its rows in turn;
// each row fetches element i, compares it with its neighbors one gap below,
// shifting each larger one up, and writes it back where the scan stops;
// draining reads and offers one element at a time and waits out any output stall. The input is
// not ready from the set_end transaction until the last result has been taken.
// Reset clears all control state; RAM contents need no clearing pass.
// Elements beyond MAX_ELEMS are dropped; set_end still closes the set.
// ---------------------------------------------------------------------------
module shell_sort_engine_core #(
    parameter int MAX_ELEMS = sse_pkg::SSE_MAX_ELEMS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // input channel
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic signed [sse_pkg::VALUE_W-1:0] elem_value,
    input  wire logic                               set_end,
    // output channel
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed      [sse_pkg::VALUE_W-1:0] sorted_value,
    output logic             [sse_pkg::TALLY_W-1:0] op_count,
    output logic                                    out_last
);

    localparam int AW = $clog2(MAX_ELEMS);
    localparam int CW = $clog2(MAX_ELEMS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ELEMS);
    localparam logic [CW-1:0] ONE_CNT = CW'(1);

    sse_pkg::sse_state_t state_reg, state_next;

    logic [CW-1:0] total_reg, total_next;   // elements loaded so far
    logic [CW-1:0] count_reg, count_next;   // size of the set under sort
    logic [CW-1:0] gap_reg,   gap_next;
    logic [CW-1:0] i_reg,     i_next;
    logic [CW-1:0] j_reg,     j_next;
    logic [CW-1:0] k_reg,     k_next;       // output index
    logic signed [sse_pkg::VALUE_W-1:0] held_reg, held_next;
    logic [sse_pkg::TALLY_W-1:0]        tally_reg, tally_next;
    logic signed [sse_pkg::VALUE_W-1:0] out_value_reg, out_value_next;
    logic                               out_last_reg, out_last_next;

    // RAM port controls
    logic                        ram_wr_en;
    logic [AW-1:0]               ram_wr_addr;
    logic [sse_pkg::VALUE_W-1:0] ram_wr_data;
    logic [AW-1:0]               ram_rd_addr;
    logic [sse_pkg::VALUE_W-1:0] ram_rd_data;

    logic          bump;        // one operation done this cycle
    logic [CW-1:0] j_less_gap;
    logic          in_fire;
    logic          has_room;

    sse_ram #(
        .WIDTH (sse_pkg::VALUE_W),
        .DEPTH (MAX_ELEMS)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign in_ready     = (state_reg == sse_pkg::ST_LOAD);
    assign in_fire      = in_valid && in_ready;
    assign has_room     = (total_reg < MAX_CNT);
    assign j_less_gap   = j_reg - gap_reg;

    assign out_valid    = (state_reg == sse_pkg::ST_OUT_HOLD);
    assign sorted_value = out_value_reg;
    assign op_count     = tally_reg;
    assign out_last     = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sse_pkg::ST_LOAD;
            total_reg    <= '0;
            count_reg    <= '0;
            gap_reg      <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            tally_reg    <= '0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            count_reg    <= count_next;
            gap_reg      <= gap_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            tally_reg    <= tally_next;
            out_last_reg <= out_last_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        held_reg      <= held_next;
        out_value_reg <= out_value_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        count_next     = count_reg;
        gap_next       = gap_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        held_next      = held_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        bump           = 1'b0;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = total_reg[AW-1:0];
        ram_wr_data    = elem_value;
        ram_rd_addr    = i_reg[AW-1:0];

        case (state_reg)
            sse_pkg::ST_LOAD:
            begin
                if (in_fire)
                begin
                    // store while there is room, drop otherwise
                    ram_wr_en = has_room;
                    if (has_room)
                    begin
                        total_next = total_reg + ONE_CNT;
                    end
                    if (set_end)
                    begin
                        count_next = has_room ? total_reg + ONE_CNT : total_reg;
                        gap_next   = count_next >> 1;
                        state_next = sse_pkg::ST_GAP;
                    end
                end
            end

            sse_pkg::ST_GAP:
            begin
                if (gap_reg == '0)
                begin
                    k_next     = '0;
                    state_next = sse_pkg::ST_OUT_RD;
                end
                else
                begin
                    i_next     = gap_reg;
                    state_next = sse_pkg::ST_ROW;
                end
            end

            sse_pkg::ST_ROW:
            begin
                if (i_reg >= count_reg)
                begin
                    // pass done: count it and halve the gap
                    bump       = 1'b1;
                    gap_next   = gap_reg >> 1;
                    state_next = sse_pkg::ST_GAP;
                end
                else
                begin
                    ram_rd_addr = i_reg[AW-1:0];
                    j_next      = i_reg;
                    state_next  = sse_pkg::ST_HELD;
                end
            end

            sse_pkg::ST_HELD:
            begin
                held_next  = ram_rd_data;
                state_next = sse_pkg::ST_TEST;
            end

            sse_pkg::ST_TEST:
            begin
                if (j_reg >= gap_reg)
                begin
                    ram_rd_addr = j_less_gap[AW-1:0];
                    state_next  = sse_pkg::ST_CMP;
                end
                else
                begin
                    state_next = sse_pkg::ST_PLACE;
                end
            end

            sse_pkg::ST_CMP:
            begin
                if ($signed(ram_rd_data) > held_reg)
                begin
                    // shift the larger neighbor up one gap
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = j_reg[AW-1:0];
                    ram_wr_data = ram_rd_data;
                    bump        = 1'b1;
                    j_next      = j_less_gap;
                    state_next  = sse_pkg::ST_TEST;
                end
                else
                begin
                    state_next = sse_pkg::ST_PLACE;
                end
            end

            sse_pkg::ST_PLACE:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = j_reg[AW-1:0];
                ram_wr_data = held_reg;
                bump        = 1'b1;
                i_next      = i_reg + ONE_CNT;
                state_next  = sse_pkg::ST_ROW;
            end

            sse_pkg::ST_OUT_RD:
            begin
                ram_rd_addr = k_reg[AW-1:0];
                state_next  = sse_pkg::ST_OUT_LD;
            end

            sse_pkg::ST_OUT_LD:
            begin
                out_value_next = ram_rd_data;
                out_last_next  = ((k_reg + ONE_CNT) == count_reg);
                state_next     = sse_pkg::ST_OUT_HOLD;
            end

            sse_pkg::ST_OUT_HOLD:
            begin
                if (out_ready)
                begin
                    if (out_last_reg)
                    begin
                        // set delivered: start a fresh one
                        total_next = '0;
                        state_next = sse_pkg::ST_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + ONE_CNT;
                        state_next = sse_pkg::ST_OUT_RD;
                    end
                end
            end

            default:
            begin
                state_next = sse_pkg::ST_LOAD;
            end
        endcase
    end

    // saturating operation tally, cleared when a set closes
    always_comb
    begin
        tally_next = tally_reg;
        if (in_fire && set_end)
        begin
            tally_next = '0;
        end
        else if (bump && (tally_reg != sse_pkg::TALLY_MAX))
        begin
            tally_next = tally_reg + 1'b1;
        end
    end

endmodule
`default_nettype wire
